@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/sbd_pkg.sv @@
// Package for the supersample box downsampler: types, constants, defaults.
package sbd_pkg;

    localparam int FACTOR_DEF        = 2;
    localparam int MAX_OUT_WIDTH_DEF = 2048;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 12;
    localparam int CFG_W   = 12;
    localparam int ROW_W   = 11;
    localparam int HEIGHT_LIMIT = 2048;

    localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 12'd1080;

    // register indexes
    localparam logic CFG_OUT_WIDTH  = 1'b0;
    localparam logic CFG_OUT_HEIGHT = 1'b1;

    // reciprocal scale for the divide by the block area
    localparam int RECIP_SHIFT = 20;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } t_rgb_sum;

endpackage

@@ rtl/sbd_ram.sv @@
// Simple dual-port RAM, one write port, one read port, registered read data.
module sbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/supersample_box_downsampler.sv @@
// Result: the word that completes a block passes the line store read, then the output register.
// Throughput: one input word per cycle while the output is not stalled; one line store read
// and one write per cycle, with a write-back forward for back-to-back access to one column.
// Reset: synchronous, active low; clears position counters and pipeline valids and loads
// out_width 1920 and out_height 1080. The line store is not cleared and needs no clearing pass.
module supersample_box_downsampler
    import sbd_pkg::*;
#(
    parameter int FACTOR        = FACTOR_DEF,
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [23:0]      i_s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,   // avg_red [7:0], avg_green [15:8], avg_blue [23:16]
    output logic             o_m_tlast    // row_end
);

    localparam int COLW = $clog2(MAX_OUT_WIDTH);
    localparam int SUBW = (FACTOR > 1) ? $clog2(FACTOR) : 1;
    localparam int AREA = FACTOR * FACTOR;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + AREA - 1) / AREA);
    localparam logic [SUBW-1:0] SUB_LAST = SUBW'(FACTOR - 1);
    localparam logic [CFG_W:0] MAX_W = (CFG_W + 1)'(MAX_OUT_WIDTH);
    localparam logic [CFG_W:0] MAX_H = (CFG_W + 1)'(HEIGHT_LIMIT);

    logic [CFG_W-1:0] r_out_width, r_out_height;
    logic [COLW-1:0]  r_out_col;
    logic [SUBW-1:0]  r_sub_col, r_sub_row;
    logic [ROW_W-1:0] r_out_row;
    t_rgb_sum         r_hsum;

    logic             r_s1_valid, r_s1_last_sc, r_s1_first_sr, r_s1_last_sr;
    logic             r_s1_row_end, r_s1_fwd;
    logic [COLW-1:0]  r_s1_addr;
    t_rgb_sum         r_s1_hsum, r_s1_fwd_data;

    logic             r_out_valid, r_out_last;
    logic [23:0]      r_out_data;

    logic             en, acc, last_sc, last_sr, col_end;
    logic [CFG_W:0]   eff_w, eff_h;
    logic [COLW-1:0]  w_last, col;
    logic [ROW_W-1:0] h_last;
    t_rgb_sum         n_hsum, base, prev, n_sum, rd_sum;
    logic [PROD_W-1:0] prod_r, prod_g, prod_b;
    logic             mem_we;

    always_comb begin
        eff_w = {1'b0, r_out_width};
        if (eff_w == '0) eff_w = (CFG_W + 1)'(1);
        if (eff_w > MAX_W) eff_w = MAX_W;
        eff_h = {1'b0, r_out_height};
        if (eff_h == '0) eff_h = (CFG_W + 1)'(1);
        if (eff_h > MAX_H) eff_h = MAX_H;
        w_last = COLW'(eff_w - (CFG_W + 1)'(1));
        h_last = ROW_W'(eff_h - (CFG_W + 1)'(1));
    end

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;
    assign last_sc    = (r_sub_col == SUB_LAST);
    assign last_sr    = (r_sub_row == SUB_LAST);
    assign col        = (r_out_col > w_last) ? w_last : r_out_col;
    assign col_end    = (col == w_last);

    always_comb begin
        base     = (r_sub_col == '0) ? '0 : r_hsum;
        n_hsum.red   = SUM_W'(base.red   + SUM_W'(i_s_tdata[7:0]));
        n_hsum.green = SUM_W'(base.green + SUM_W'(i_s_tdata[15:8]));
        n_hsum.blue  = SUM_W'(base.blue  + SUM_W'(i_s_tdata[23:16]));
    end

    always_comb begin
        prev = r_s1_first_sr ? '0 : (r_s1_fwd ? r_s1_fwd_data : rd_sum);
        n_sum.red   = SUM_W'(prev.red   + r_s1_hsum.red);
        n_sum.green = SUM_W'(prev.green + r_s1_hsum.green);
        n_sum.blue  = SUM_W'(prev.blue  + r_s1_hsum.blue);
        prod_r = PROD_W'(n_sum.red)   * PROD_W'(RECIP);
        prod_g = PROD_W'(n_sum.green) * PROD_W'(RECIP);
        prod_b = PROD_W'(n_sum.blue)  * PROD_W'(RECIP);
    end

    assign mem_we = en && r_s1_valid && r_s1_last_sc;

    sbd_ram #(
        .WIDTH ($bits(t_rgb_sum)),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_sum),
        .i_re    (acc),
        .i_raddr (col),
        .o_rdata (rd_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_WIDTH_RST;
            r_out_height <= OUT_HEIGHT_RST;
            r_out_col    <= '0;
            r_sub_col    <= '0;
            r_sub_row    <= '0;
            r_out_row    <= '0;
            r_hsum       <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OUT_WIDTH:  r_out_width  <= i_cfg_wdata;
                    CFG_OUT_HEIGHT: r_out_height <= i_cfg_wdata;
                    default: ;
                endcase
                r_out_col <= '0;
                r_sub_col <= '0;
                r_sub_row <= '0;
                r_out_row <= '0;
                r_hsum    <= '0;
            end else if (acc) begin
                r_hsum <= n_hsum;
                if (last_sc) begin
                    r_sub_col <= '0;
                    if (col_end) begin
                        r_out_col <= '0;
                        if (last_sr) begin
                            r_sub_row <= '0;
                            r_out_row <= (r_out_row >= h_last) ? '0 : r_out_row + 1'b1;
                        end else begin
                            r_sub_row <= r_sub_row + 1'b1;
                        end
                    end else begin
                        r_out_col <= col + 1'b1;
                    end
                end else begin
                    r_sub_col <= r_sub_col + 1'b1;
                end
            end
            if (en) begin
                r_s1_valid <= acc;
            end
            if (mem_we && r_s1_last_sr) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_last_sc  <= last_sc;
            r_s1_first_sr <= (r_sub_row == '0);
            r_s1_last_sr  <= last_sr;
            r_s1_row_end  <= col_end;
            r_s1_addr     <= col;
            r_s1_hsum     <= n_hsum;
            r_s1_fwd      <= mem_we && (r_s1_addr == col);
            r_s1_fwd_data <= n_sum;
        end
        if (mem_we && r_s1_last_sr) begin
            r_out_data <= {prod_b[RECIP_SHIFT +: PIX_W], prod_g[RECIP_SHIFT +: PIX_W],
                           prod_r[RECIP_SHIFT +: PIX_W]};
            r_out_last <= r_s1_row_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

@@ rtl/sbd_checker.sv @@
// Port-level checker for the supersample box downsampler, bound to the top level.
`include "assert_macros.svh"

module sbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic [24:0] out_word;

    assign out_word = {o_m_tlast, o_m_tdata};

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(out_word))
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid && !i_m_tready)
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind supersample_box_downsampler sbd_checker u_sbd_checker (.*);

@@ bench/supersample_box_downsampler_tb.sv @@
// Self-checking testbench for the supersampled 2x2 box-average downsampler.
`timescale 1ns / 1ps

module supersample_box_downsampler_tb;
    import sbd_pkg::*;

    localparam int FACTOR       = FACTOR_DEF;
    localparam int AREA         = FACTOR * FACTOR;
    localparam int MAX_WIDTH    = MAX_OUT_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic       row_end;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix_out;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [23:0]      i_s_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [23:0]      o_m_tdata;   // avg_red [7:0], avg_green [15:8], avg_blue [23:16]
    logic             o_m_tlast;   // row_end

    supersample_box_downsampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // averaging model state
    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;
    int unsigned      width_eff;
    int unsigned      height_eff;
    t_rgb_sum         col_sums_model [MAX_WIDTH];
    t_rgb_sum         row_sum_model;
    int unsigned      col_pos;
    int unsigned      sub_col_pos;
    int unsigned      sub_row_pos;
    int unsigned      out_row_pos;

    t_pix_out    pending_avgs[$];
    t_pix_out    want_avg;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_avgs.size());
            $display("supersample_box_downsampler_tb failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_avgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: data %h last %b",
                             o_m_tdata, o_m_tlast);
            end else begin
                want_avg = pending_avgs.pop_front();
                if (o_m_tdata[7:0] !== want_avg.red || o_m_tdata[15:8] !== want_avg.green ||
                    o_m_tdata[23:16] !== want_avg.blue || o_m_tlast !== want_avg.row_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at output %0d: want data %h last %b, got %h last %b",
                                 results_seen, {want_avg.blue, want_avg.green, want_avg.red},
                                 want_avg.row_end, o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    function automatic void restart_frame_model();
        row_sum_model = '0;
        col_pos       = 0;
        sub_col_pos   = 0;
        sub_row_pos   = 0;
        out_row_pos   = 0;
    endfunction

    // Folds one supersampled pixel into the block sums; queues the average
    // when the bottom-right pixel of a block arrives.
    function automatic void box_average_pixel(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        int unsigned col;
        t_rgb_sum    prev;
        t_pix_out    avg;
        col = (col_pos >= width_eff) ? width_eff - 1 : col_pos;
        if (sub_col_pos == 0)
            row_sum_model = '0;
        row_sum_model.red   = row_sum_model.red   + SUM_W'(r);
        row_sum_model.green = row_sum_model.green + SUM_W'(g);
        row_sum_model.blue  = row_sum_model.blue  + SUM_W'(b);
        if (sub_col_pos + 1 >= FACTOR) begin
            sub_col_pos = 0;
            prev = (sub_row_pos == 0) ? t_rgb_sum'('0) : col_sums_model[col];
            col_sums_model[col].red   = prev.red   + row_sum_model.red;
            col_sums_model[col].green = prev.green + row_sum_model.green;
            col_sums_model[col].blue  = prev.blue  + row_sum_model.blue;
            if (sub_row_pos + 1 >= FACTOR) begin
                avg.red     = 8'(col_sums_model[col].red / AREA);
                avg.green   = 8'(col_sums_model[col].green / AREA);
                avg.blue    = 8'(col_sums_model[col].blue / AREA);
                avg.row_end = (col + 1 == width_eff);
                pending_avgs.push_back(avg);
            end
            if (col + 1 >= width_eff) begin
                col_pos = 0;
                if (sub_row_pos + 1 >= FACTOR) begin
                    sub_row_pos = 0;
                    out_row_pos = (out_row_pos + 1 >= height_eff) ? 0 : out_row_pos + 1;
                end else begin
                    sub_row_pos++;
                end
            end else begin
                col_pos = col + 1;
            end
        end else begin
            sub_col_pos++;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 24'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!o_s_tready);
        box_average_pixel(r, g, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_avgs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_OUT_WIDTH)
            width_cfg = val;
        else
            height_cfg = val;
        width_eff  = (width_cfg == 0) ? 1 : width_cfg;
        if (width_eff > MAX_WIDTH)
            width_eff = MAX_WIDTH;
        height_eff = (height_cfg == 0) ? 1 : height_cfg;
        if (height_eff > HEIGHT_LIMIT)
            height_eff = HEIGHT_LIMIT;
        restart_frame_model();
        @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        write_reg(CFG_OUT_WIDTH, 12'd1);
        write_reg(CFG_OUT_HEIGHT, 12'd1);
        repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
        // truncation of the divide
        send_pixel(8'd3, 8'hFF, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd2);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_zero_size();
        write_reg(CFG_OUT_WIDTH, 12'd0);
        write_reg(CFG_OUT_HEIGHT, 12'd0);
        send_pixel(8'hFF, 8'h00, 8'h80);
        send_pixel(8'hFE, 8'h01, 8'h7F);
        send_pixel(8'h00, 8'hFF, 8'h01);
        send_pixel(8'h01, 8'hFE, 8'h00);
        wait_drained();
    endtask

    task automatic test_mid_frame_restart();
        write_reg(CFG_OUT_WIDTH, 12'd2);
        write_reg(CFG_OUT_HEIGHT, 12'hFFF);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        send_pixel(8'hAA, 8'h55, 8'hF0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        wait_drained();
        // half a block is pending; the write throws it away
        write_reg(CFG_OUT_HEIGHT, 12'd2048);
        repeat (2) begin
            send_pixel(8'hFF, 8'h00, 8'hFF);
            send_pixel(8'h00, 8'hFF, 8'h00);
            send_pixel(8'h80, 8'h7F, 8'h01);
            send_pixel(8'h7F, 8'h80, 8'hFE);
        end
        wait_drained();
    endtask

    task automatic test_widest_row();
        send_idle_pct  = 0;
        recv_stall_pct = 17;
        wait_drained();
        // above the line store depth: clamps to the full store
        write_reg(CFG_OUT_WIDTH, 12'hFFF);
        write_reg(CFG_OUT_HEIGHT, 12'hFFF);
        repeat (64) send_pixel(rand_byte(), rand_byte(), rand_byte());
        wait_drained();
        write_reg(CFG_OUT_WIDTH, 12'd2048);
        repeat (24) send_pixel(rand_byte(), rand_byte(), rand_byte());
        wait_drained();
    endtask

    task automatic run_random_phase(input int unsigned idle_s, input int unsigned stall_r,
                                    input int unsigned n_words);
        int unsigned start;
        int unsigned pick;
        int unsigned w_req;
        int unsigned per_row;
        int unsigned n;
        send_idle_pct  = idle_s;
        recv_stall_pct = stall_r;
        start = items_sent;
        while (items_sent - start < n_words) begin
            wait_drained();
            pick = $urandom_range(99);
            if (pick < 65)
                w_req = $urandom_range(6, 1);
            else if (pick < 88)
                w_req = $urandom_range(40, 7);
            else if (pick < 94)
                w_req = 0;
            else
                w_req = $urandom_range(4095, 41);
            if ($urandom_range(9) != 0)
                write_reg(CFG_OUT_WIDTH, 12'(w_req));
            if ($urandom_range(3) == 0)
                write_reg(CFG_OUT_HEIGHT,
                          $urandom_range(1) ? 12'($urandom_range(3)) : 12'($urandom));
            per_row = AREA * width_eff;
            if (width_eff > 40) begin
                n = $urandom_range(40, 1);
            end else begin
                n = per_row * $urandom_range(1 + 120 / per_row, 1);
                // broken frame: stop inside a block row
                if ($urandom_range(6) == 0)
                    n += $urandom_range(per_row - 1, 1);
            end
            repeat (n) send_pixel(rand_byte(), rand_byte(), rand_byte());
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 220);
        run_random_phase(83, 0, 220);
        run_random_phase(0, 83, 220);
        run_random_phase(17, 17, 220);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_OUT_WIDTH;
        i_cfg_wdata    = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        width_cfg      = OUT_WIDTH_RST;
        height_cfg     = OUT_HEIGHT_RST;
        width_eff      = OUT_WIDTH_RST;
        height_eff     = OUT_HEIGHT_RST;
        restart_frame_model();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_extremes();
        test_zero_size();
        test_mid_frame_restart();
        test_widest_row();
        test_random_traffic();

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (pending_avgs.size() != 0)
            $display("%0d averaged words never arrived", pending_avgs.size());
        $display("%0d pixel words in, %0d averaged words out, %0d mismatches", items_sent,
                 results_seen, mismatches);
        $display("widths 0 to 4095 incl. clamp to full line store, heights 0 to 4095, %s",
                 "mid-frame restarts and four idle/stall mixes");
        if (mismatches == 0 && pending_avgs.size() == 0) begin
            $display("supersample_box_downsampler_tb passed");
        end else begin
            $display("supersample_box_downsampler_tb failed");
        end
        $finish;
    end

endmodule

@@ supersample_box_downsampler.f @@
+incdir+rtl
rtl/sbd_pkg.sv
rtl/sbd_ram.sv
rtl/supersample_box_downsampler.sv
rtl/sbd_checker.sv
bench/supersample_box_downsampler_tb.sv
